// ===== rtl/hgsn_pkg.sv =====
// ----------------------------------------------------------------------------
// hgsn_pkg
// Shared types, codes, defaults and the distance colour table for the
// hop-count gradient seed node.
// ----------------------------------------------------------------------------
package hgsn_pkg;

	typedef logic [14:0] colour_t;

	// Item command codes.
	localparam logic CMD_MESSAGE = 1'b0;
	localparam logic CMD_TICK    = 1'b1;

	// Configuration register indexes.
	localparam logic [2:0] CFG_NODE_ID           = 3'd0;
	localparam logic [2:0] CFG_NEWEST_SEED_MODE  = 3'd1;
	localparam logic [2:0] CFG_AGING_ENABLE      = 3'd2;
	localparam logic [2:0] CFG_BLINK_ENABLE      = 3'd3;
	localparam logic [2:0] CFG_BLINK_TOTAL_TIME  = 3'd4;
	localparam logic [2:0] CFG_BLINK_HALF_PERIOD = 3'd5;

	// Parameter defaults.
	localparam int MAX_DISTANCE_DEF   = 250;
	localparam int STALE_AFTER_MS_DEF = 800;
	localparam int MIN_PAYLOAD_DEF    = 8;

	// Register reset values.
	localparam logic [15:0] BLINK_TOTAL_RST = 16'd200;
	localparam logic [15:0] BLINK_HALF_RST  = 16'd50;

	// Colours pack red in [4:0], green in [9:5] and blue in [14:10].
	localparam colour_t COLOUR_OFF = 15'd0;
	localparam colour_t WHITE_RGB  = {5'd25, 5'd25, 5'd25};

	localparam colour_t PALETTE [8] = '{
		{5'd0,  5'd0,  5'd25},   // red
		{5'd0,  5'd10, 5'd25},   // orange
		{5'd0,  5'd25, 5'd25},   // yellow
		{5'd0,  5'd25, 5'd0},    // green
		{5'd25, 5'd25, 5'd0},    // cyan
		{5'd25, 5'd0,  5'd0},    // blue
		{5'd25, 5'd0,  5'd10},   // violet
		{5'd25, 5'd0,  5'd25}    // magenta
	};

	// Distance zero is the seed itself and shows white; other distances cycle
	// through the eight palette entries.
	function automatic colour_t colour_of(input logic [7:0] hops);
		logic [7:0] idx;
		idx = hops - 8'd1;
		if (hops == 8'd0) begin
			return WHITE_RGB;
		end
		return PALETTE[idx[2:0]];
	endfunction

endpackage

// ===== rtl/hop_gradient_seed_node_core.sv =====
// ----------------------------------------------------------------------------
// hop_gradient_seed_node_core
// One node of a hop-count gradient: tracks the best seed heard from
// neighbors, its hop distance, route aging and a blinking status LED.
// ----------------------------------------------------------------------------
// A request accepted into the input register is worked on by the update
// logic and moves into the result register once that register is free.
// Throughput: one request per cycle, sustained while result_stall is low;
// the update logic sits between the input register and the result register.
// Reset (arst_n low, asynchronous) clears the node state, the configuration
// registers to their defaults and both pipeline valid flags.
module hop_gradient_seed_node_core #(
	parameter int MAX_DISTANCE   = hgsn_pkg::MAX_DISTANCE_DEF,
	parameter int STALE_AFTER_MS = hgsn_pkg::STALE_AFTER_MS_DEF,
	parameter int MIN_PAYLOAD    = hgsn_pkg::MIN_PAYLOAD_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	// Configuration write port.
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,

	// Request channel.
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        command,
	input  logic [31:0] now_time,
	input  logic [7:0]  msg_length,
	input  logic [15:0] msg_seed_id,
	input  logic [31:0] msg_seed_time,
	input  logic [15:0] msg_distance,
	input  logic        become_seed,

	// Result channel.
	output logic        result_valid,
	input  logic        result_stall,
	output logic        seed_known,
	output logic [15:0] cur_seed_id,
	output logic [31:0] cur_seed_time,
	output logic [7:0]  cur_distance,
	output logic [4:0]  led_red,
	output logic [4:0]  led_green,
	output logic [4:0]  led_blue,
	output logic        changed
);

	import hgsn_pkg::*;

	localparam logic [7:0]  MAX_DIST_W = 8'(MAX_DISTANCE);
	localparam logic [31:0] AGE_LIMIT  = 32'(STALE_AFTER_MS);
	localparam logic [7:0]  MIN_LEN    = 8'(MIN_PAYLOAD);

	// Configuration registers.
	logic [15:0] node_id_q;
	logic        newest_seed_mode_q;
	logic        aging_enable_q;
	logic        blink_enable_q;
	logic [15:0] blink_total_time_q;
	logic [15:0] blink_half_period_q;

	// Node state.
	logic        first_pending_q;
	logic        have_seed_q;
	logic [15:0] held_seed_id_q;
	logic [31:0] held_seed_time_q;
	logic [7:0]  hop_distance_q;
	logic [31:0] route_refresh_time_q;
	logic        blink_active_q;
	logic [31:0] blink_end_time_q;
	logic [31:0] next_toggle_time_q;
	logic        blink_phase_on_q;
	colour_t     target_colour_q;
	colour_t     led_colour_q;

	// Input register (stage 1).
	logic        valid_s1;
	logic        command_s1;
	logic [31:0] now_time_s1;
	logic [7:0]  msg_length_s1;
	logic [15:0] msg_seed_id_s1;
	logic [31:0] msg_seed_time_s1;
	logic [15:0] msg_distance_s1;
	logic        become_seed_s1;

	// Result register (stage 2).
	logic        valid_s2;
	logic        seed_known_s2;
	logic [15:0] seed_id_s2;
	logic [31:0] seed_time_s2;
	logic [7:0]  distance_s2;
	colour_t     led_s2;
	logic        changed_s2;

	// Next-state values computed from the request in stage 1.
	logic        n_have;
	logic [15:0] n_id;
	logic [31:0] n_time;
	logic [7:0]  n_dist;
	logic [31:0] n_ref;
	logic        n_active;
	logic [31:0] n_end;
	logic [31:0] n_toggle;
	logic        n_phase;
	colour_t     n_target;
	colour_t     n_led;
	logic        n_chg;

	logic advance;
	logic load_s1;

	// Stage 1 moves into the result register whenever the result register is
	// empty or its content is being taken in the same cycle.  The input
	// register still takes a new request while an older result waits, if it is empty.
	assign advance    = valid_s1 && (!valid_s2 || !result_stall);
	assign item_stall = valid_s1 && !advance;
	assign load_s1    = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_id_q           <= 16'd0;
			newest_seed_mode_q  <= 1'b1;
			aging_enable_q      <= 1'b1;
			blink_enable_q      <= 1'b1;
			blink_total_time_q  <= BLINK_TOTAL_RST;
			blink_half_period_q <= BLINK_HALF_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_NODE_ID:           node_id_q           <= cfg_data;
				CFG_NEWEST_SEED_MODE:  newest_seed_mode_q  <= cfg_data[0];
				CFG_AGING_ENABLE:      aging_enable_q      <= cfg_data[0];
				CFG_BLINK_ENABLE:      blink_enable_q      <= cfg_data[0];
				CFG_BLINK_TOTAL_TIME:  blink_total_time_q  <= cfg_data;
				CFG_BLINK_HALF_PERIOD: blink_half_period_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			command_s1       <= command;
			now_time_s1      <= now_time;
			msg_length_s1    <= msg_length;
			msg_seed_id_s1   <= msg_seed_id;
			msg_seed_time_s1 <= msg_seed_time;
			msg_distance_s1  <= msg_distance;
			become_seed_s1   <= become_seed;
		end
	end

	// Update logic.  The first request after reset in lowest-id mode first
	// installs this node as seed; the request is then handled on top of that.
	always_comb begin
		logic        inst;
		logic        h_have;
		logic [15:0] h_id;
		logic [31:0] h_time;
		logic [7:0]  h_dist;
		logic [31:0] h_ref;
		logic [16:0] cd_wide;
		logic [7:0]  cd;
		logic        msg_ok;
		logic        newer;
		logic        same;
		logic        upd;
		logic [31:0] age;
		colour_t     col;

		inst   = first_pending_q && !newest_seed_mode_q;
		h_have = have_seed_q || inst;
		h_id   = inst ? node_id_q : held_seed_id_q;
		h_time = inst ? 32'd1 : held_seed_time_q;
		h_dist = inst ? 8'd0 : hop_distance_q;
		h_ref  = inst ? now_time_s1 : route_refresh_time_q;

		// Candidate distance through the neighbor, saturating.
		cd_wide = {1'b0, msg_distance_s1} + 17'd1;
		cd      = (cd_wide > 17'(MAX_DISTANCE)) ? MAX_DIST_W : cd_wide[7:0];
		msg_ok  = (msg_length_s1 >= MIN_LEN) && (msg_seed_time_s1 != 32'd0);

		if (newest_seed_mode_q) begin
			newer = (msg_seed_time_s1 != h_time) ? (msg_seed_time_s1 > h_time)
			                                     : (msg_seed_id_s1 < h_id);
			same  = (msg_seed_time_s1 == h_time) && (msg_seed_id_s1 == h_id);
		end else begin
			newer = msg_seed_id_s1 < h_id;
			same  = msg_seed_id_s1 == h_id;
		end

		age = now_time_s1 - h_ref;

		n_have   = h_have;
		n_id     = h_id;
		n_time   = h_time;
		n_dist   = h_dist;
		n_ref    = h_ref;
		n_active = blink_active_q;
		n_end    = blink_end_time_q;
		n_toggle = next_toggle_time_q;
		n_phase  = blink_phase_on_q;
		n_target = target_colour_q;
		n_led    = led_colour_q;
		upd      = 1'b0;

		if (command_s1 == CMD_TICK) begin
			if (newest_seed_mode_q && become_seed_s1) begin
				n_have = 1'b1;
				n_id   = node_id_q;
				n_time = now_time_s1;
				n_dist = 8'd0;
				upd    = 1'b1;
			end
			// Aging cannot follow a self-seed, since that leaves distance zero.
			if (aging_enable_q && n_have && (n_dist != 8'd0) && (n_dist < MAX_DIST_W)
			    && (age > AGE_LIMIT)) begin
				n_dist = n_dist + 8'd1;
				n_ref  = now_time_s1;
				upd    = 1'b1;
			end
		end else if (msg_ok) begin
			if (!h_have || newer || (same && (cd < h_dist))) begin
				n_have = 1'b1;
				n_id   = msg_seed_id_s1;
				n_time = msg_seed_time_s1;
				n_dist = cd;
				n_ref  = now_time_s1;
				upd    = 1'b1;
			end else if (same && (cd == h_dist)) begin
				n_ref = now_time_s1;
			end
		end

		col = colour_of(n_dist);

		// A change starts a blink in the colour of the new distance when blinking is enabled.
		if (upd && blink_enable_q) begin
			n_target = col;
			n_active = 1'b1;
			n_end    = now_time_s1 + {16'd0, blink_total_time_q};
			n_toggle = now_time_s1 + {16'd0, blink_half_period_q};
			n_phase  = 1'b1;
			n_led    = col;
		end

		// Ticks refresh the steady colour and advance the blink.
		if (command_s1 == CMD_TICK) begin
			n_target = n_have ? col : COLOUR_OFF;
			if (!n_active) begin
				n_led = n_target;
			end else if (now_time_s1 >= n_end) begin
				n_active = 1'b0;
				n_led    = n_target;
			end else if (now_time_s1 >= n_toggle) begin
				n_toggle = n_toggle + {16'd0, blink_half_period_q};
				n_phase  = !n_phase;
				n_led    = n_phase ? n_target : COLOUR_OFF;
			end
		end

		n_chg = inst || upd;
	end

	// Node state commits when the request leaves stage 1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_pending_q      <= 1'b1;
			have_seed_q          <= 1'b0;
			held_seed_id_q       <= 16'd0;
			held_seed_time_q     <= 32'd0;
			hop_distance_q       <= MAX_DIST_W;
			route_refresh_time_q <= 32'd0;
			blink_active_q       <= 1'b0;
			blink_end_time_q     <= 32'd0;
			next_toggle_time_q   <= 32'd0;
			blink_phase_on_q     <= 1'b0;
			target_colour_q      <= COLOUR_OFF;
			led_colour_q         <= COLOUR_OFF;
		end else if (advance) begin
			first_pending_q      <= 1'b0;
			have_seed_q          <= n_have;
			held_seed_id_q       <= n_id;
			held_seed_time_q     <= n_time;
			hop_distance_q       <= n_dist;
			route_refresh_time_q <= n_ref;
			blink_active_q       <= n_active;
			blink_end_time_q     <= n_end;
			next_toggle_time_q   <= n_toggle;
			blink_phase_on_q     <= n_phase;
			target_colour_q      <= n_target;
			led_colour_q         <= n_led;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			seed_known_s2 <= n_have;
			seed_id_s2    <= n_id;
			seed_time_s2  <= n_time;
			distance_s2   <= n_dist;
			led_s2        <= n_led;
			changed_s2    <= n_chg;
		end
	end

	assign result_valid  = valid_s2;
	assign seed_known    = seed_known_s2;
	assign cur_seed_id   = seed_id_s2;
	assign cur_seed_time = seed_time_s2;
	assign cur_distance  = distance_s2;
	assign led_red       = led_s2[4:0];
	assign led_green     = led_s2[9:5];
	assign led_blue      = led_s2[14:10];
	assign changed       = changed_s2;

endmodule
